[hdl/madt_pkg.sv]
// Shared types and constants for the MADT interrupt override parser.
package madt_pkg;

  localparam logic OP_FEED  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [7:0] TYPE_IOAPIC   = 8'd1;
  localparam logic [7:0] TYPE_OVERRIDE = 8'd2;

  localparam logic [7:0] OFS_TYPE      = 8'd0;
  localparam logic [7:0] OFS_LENGTH    = 8'd1;
  localparam logic [7:0] OFS_SRC_IRQ   = 8'd3;
  localparam logic [7:0] OFS_GSI_LOW   = 8'd4;
  localparam logic [7:0] OFS_ADDR_LO   = 8'd4;
  localparam logic [7:0] OFS_ADDR_HI   = 8'd7;
  localparam logic [7:0] OFS_FLAGS     = 8'd8;
  localparam logic [7:0] MIN_OVR_LEN   = 8'd10;
  localparam logic [7:0] MIN_BODY_LEN  = 8'd2;

  localparam logic [1:0] FLAG_PAIR     = 2'h3;
  localparam int         TRIGGER_SHIFT = 2;

  typedef struct packed {
    logic       level;
    logic       low;
    logic [7:0] gsi;
  } ovr_entry_t;

  typedef struct packed {
    logic       en;
    logic [7:0] irq;
    ovr_entry_t entry;
  } ovr_wr_t;

  typedef struct packed {
    logic [31:0] ioapic_now;
    logic        aborted_now;
    logic [31:0] ioapic_fed;
    logic        aborted_fed;
  } parse_stat_t;

endpackage

[hdl/madt_ifs.sv]
// Valid/ready channel interfaces for the input and result items.
interface madt_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] table_byte;
  logic       end_of_table;
  logic [7:0] query_irq;

  modport source (output valid, op, table_byte, end_of_table, query_irq, input ready);
  modport sink   (input valid, op, table_byte, end_of_table, query_irq, output ready);
endinterface

interface madt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  mapped_gsi;
  logic        is_active_low;
  logic        is_level;
  logic        has_override;
  logic [31:0] ioapic_address;
  logic        parse_aborted;

  modport source (output valid, mapped_gsi, is_active_low, is_level, has_override,
                  ioapic_address, parse_aborted, input ready);
  modport sink   (input valid, mapped_gsi, is_active_low, is_level, has_override,
                  ioapic_address, parse_aborted, output ready);
endinterface

[hdl/madt_parser.sv]
// Byte-wise MADT entry parser: field registers and override write command.
module madt_parser
  import madt_pkg::*;
#(
  parameter int IRQ_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        feed,
  input  logic [7:0]  table_byte,
  input  logic        end_of_table,
  output ovr_wr_t     wr,
  output parse_stat_t stat
);

  logic [7:0]  entry_offset, entry_offset_next;
  logic [7:0]  entry_type, entry_type_next;
  logic [7:0]  entry_length, entry_length_next;
  logic [7:0]  source_irq, source_irq_next;
  logic [7:0]  gsi_low, gsi_low_next;
  logic [31:0] address_shift, address_shift_next;
  logic [31:0] ioapic_register, ioapic_register_next;
  logic        aborted_flag, aborted_flag_next;
  logic [8:0]  offset_inc;
  logic        src_in_range;

  assign offset_inc   = {1'b0, entry_offset} + 9'd1;
  assign src_in_range = {1'b0, source_irq} < 9'(IRQ_SLOTS);

  always_comb begin
    entry_offset_next    = entry_offset;
    entry_type_next      = entry_type;
    entry_length_next    = entry_length;
    source_irq_next      = source_irq;
    gsi_low_next         = gsi_low;
    address_shift_next   = address_shift;
    ioapic_register_next = ioapic_register;
    aborted_flag_next    = aborted_flag;
    wr                   = '0;
    stat.ioapic_now      = ioapic_register;
    stat.aborted_now     = aborted_flag;
    stat.ioapic_fed      = ioapic_register;
    stat.aborted_fed     = aborted_flag;

    if (feed) begin
      if (!aborted_flag) begin
        if (entry_offset == OFS_TYPE) begin
          entry_type_next    = table_byte;
          address_shift_next = '0;
          entry_offset_next  = OFS_LENGTH;
        end else if (entry_offset == OFS_LENGTH) begin
          entry_length_next = table_byte;
          if (table_byte == 8'd0) begin
            aborted_flag_next = 1'b1;
            entry_offset_next = OFS_TYPE;
          end else if (table_byte <= MIN_BODY_LEN) begin
            entry_offset_next = OFS_TYPE;
          end else begin
            entry_offset_next = MIN_BODY_LEN;
          end
        end else begin
          case (entry_type)
            TYPE_IOAPIC: begin
              if (entry_offset >= OFS_ADDR_LO && entry_offset <= OFS_ADDR_HI) begin
                // little endian: byte lane is offset minus four, i.e. offset[1:0]
                address_shift_next = address_shift |
                                     (32'(table_byte) << {entry_offset[1:0], 3'b000});
              end
              if (entry_offset == OFS_ADDR_HI) begin
                ioapic_register_next = address_shift_next;
              end
            end
            TYPE_OVERRIDE: begin
              if (entry_offset == OFS_SRC_IRQ) begin
                source_irq_next = table_byte;
              end else if (entry_offset == OFS_GSI_LOW) begin
                gsi_low_next = table_byte;
              end else if (entry_offset == OFS_FLAGS && entry_length >= MIN_OVR_LEN &&
                           src_in_range) begin
                wr.en          = 1'b1;
                wr.irq         = source_irq;
                wr.entry.gsi   = gsi_low;
                wr.entry.low   = (table_byte[1:0] == FLAG_PAIR);
                wr.entry.level = (table_byte[TRIGGER_SHIFT +: 2] == FLAG_PAIR);
              end
            end
            default: ;
          endcase
          if (offset_inc >= {1'b0, entry_length}) begin
            entry_offset_next = OFS_TYPE;
          end else begin
            entry_offset_next = offset_inc[7:0];
          end
        end
      end

      stat.ioapic_fed  = ioapic_register_next;
      stat.aborted_fed = aborted_flag_next;

      // last byte restarts the entry parse and clears the abort
      if (end_of_table) begin
        entry_offset_next  = OFS_TYPE;
        address_shift_next = '0;
        aborted_flag_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_offset    <= '0;
      entry_type      <= '0;
      entry_length    <= '0;
      source_irq      <= '0;
      gsi_low         <= '0;
      address_shift   <= '0;
      ioapic_register <= '0;
      aborted_flag    <= 1'b0;
    end else begin
      entry_offset    <= entry_offset_next;
      entry_type      <= entry_type_next;
      entry_length    <= entry_length_next;
      source_irq      <= source_irq_next;
      gsi_low         <= gsi_low_next;
      address_shift   <= address_shift_next;
      ioapic_register <= ioapic_register_next;
      aborted_flag    <= aborted_flag_next;
    end
  end

endmodule

[hdl/madt_ovr_store.sv]
// Override table: synchronous-read memory plus per-slot present bits.
module madt_ovr_store
  import madt_pkg::*;
#(
  parameter int IRQ_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  ovr_wr_t    wr,
  input  logic       rd_en,
  input  logic [7:0] rd_irq,
  output logic       rd_hit,
  output ovr_entry_t rd_entry
);

  localparam int SLOT_W = (IRQ_SLOTS > 1) ? $clog2(IRQ_SLOTS) : 1;

  ovr_entry_t           mem [IRQ_SLOTS];
  logic [IRQ_SLOTS-1:0] present;
  logic [SLOT_W-1:0]    widx;
  logic [SLOT_W-1:0]    ridx;
  logic                 rd_in_range;

  assign widx        = wr.irq[SLOT_W-1:0];
  assign ridx        = rd_irq[SLOT_W-1:0];
  assign rd_in_range = {1'b0, rd_irq} < 9'(IRQ_SLOTS);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[widx] <= wr.entry;
    end
    if (rd_en) begin
      rd_entry <= mem[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (wr.en) begin
        present[widx] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= rd_in_range && present[ridx];
      end
    end
  end

endmodule

[hdl/madt_irq_override_parser.sv]
// Top level of the MADT interrupt source override parser.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    op, table_byte, end_of_table, query_irq
//   out_ch    out   valid/ready    mapped_gsi, is_active_low, is_level,
//                                  has_override, ioapic_address, parse_aborted
//
// One item per cycle sustained while the output is not stalled; a result passes
// the read stage (memory read at the accept edge) and then the output register.
// Table bytes update the parser registers at the accept edge; an override
// write lands in memory there, so a query accepted next cycle sees it.
// rst (synchronous) clears the parser, the present bits and both stages.
// A stalled output holds; input stays ready while the read stage can drain.
module madt_irq_override_parser
  import madt_pkg::*;
#(
  parameter int IRQ_SLOTS = 16
) (
  input logic        clk,
  input logic        rst,
  madt_in_if.sink    in_ch,
  madt_out_if.source out_ch
);

  logic        in_acc;
  logic        feed;
  logic        query;
  ovr_wr_t     wr;
  parse_stat_t stat;
  logic        rd_hit;
  ovr_entry_t  rd_entry;

  logic        s1_valid;
  logic        s1_query;
  logic [7:0]  s1_irq;
  logic [31:0] s1_ioapic;
  logic        s1_aborted;
  logic        s1_adv;

  logic        out_valid;
  logic [7:0]  out_gsi;
  logic        out_low;
  logic        out_level;
  logic        out_has;
  logic [31:0] out_ioapic;
  logic        out_aborted;

  assign s1_adv      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign feed        = in_acc && (in_ch.op == OP_FEED);
  assign query       = in_acc && (in_ch.op == OP_QUERY);

  madt_parser #(.IRQ_SLOTS(IRQ_SLOTS)) u_parser (
    .clk          (clk),
    .rst          (rst),
    .feed         (feed),
    .table_byte   (in_ch.table_byte),
    .end_of_table (in_ch.end_of_table),
    .wr           (wr),
    .stat         (stat)
  );

  madt_ovr_store #(.IRQ_SLOTS(IRQ_SLOTS)) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_en    (query),
    .rd_irq   (in_ch.query_irq),
    .rd_hit   (rd_hit),
    .rd_entry (rd_entry)
  );

  // read stage: waits for memory data alongside the status snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_query   <= (in_ch.op == OP_QUERY);
      s1_irq     <= in_ch.query_irq;
      s1_ioapic  <= query ? stat.ioapic_now : stat.ioapic_fed;
      s1_aborted <= query ? stat.aborted_now : stat.aborted_fed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ioapic  <= s1_ioapic;
      out_aborted <= s1_aborted;
      if (!s1_query) begin
        out_gsi   <= '0;
        out_low   <= 1'b0;
        out_level <= 1'b0;
        out_has   <= 1'b0;
      end else if (rd_hit) begin
        out_gsi   <= rd_entry.gsi;
        out_low   <= rd_entry.low;
        out_level <= rd_entry.level;
        out_has   <= 1'b1;
      end else begin
        out_gsi   <= s1_irq;
        out_low   <= 1'b0;
        out_level <= 1'b0;
        out_has   <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.mapped_gsi     = out_gsi;
  assign out_ch.is_active_low  = out_low;
  assign out_ch.is_level       = out_level;
  assign out_ch.has_override   = out_has;
  assign out_ch.ioapic_address = out_ioapic;
  assign out_ch.parse_aborted  = out_aborted;

endmodule

[hdl/madt_chk.sv]
// Port-level checker for the MADT override parser, bound to the top level.
module madt_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_gsi,
  input logic        out_low,
  input logic        out_level,
  input logic        out_has,
  input logic [31:0] out_ioapic,
  input logic        out_aborted
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_gsi) && $stable(out_low) &&
      $stable(out_level) && $stable(out_has) && $stable(out_ioapic) && $stable(out_aborted))
    else $error("stalled result changed");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("no result two cycles after an accepted item");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  a_flags_need_override: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_has |-> !out_low && !out_level)
    else $error("polarity or trigger flag set without an override");

endmodule

bind madt_irq_override_parser madt_chk u_madt_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_gsi     (out_ch.mapped_gsi),
  .out_low     (out_ch.is_active_low),
  .out_level   (out_ch.is_level),
  .out_has     (out_ch.has_override),
  .out_ioapic  (out_ch.ioapic_address),
  .out_aborted (out_ch.parse_aborted)
);
